// ===== rtl/ppfl_pkg.sv =====
// Shared types and constants of the page free list allocator.
`timescale 1ns / 1ps
`default_nettype none

package ppfl_pkg;

	localparam int ADDR_W        = 40;
	localparam int COUNT_OUT_W   = 16;
	localparam int CFG_IDX_W     = 1;
	localparam int DEF_PAGE_SIZE = 4096;
	localparam int DEF_MAX_PAGES = 32768;

	localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_LIMIT = 1'd1;

	typedef enum logic [1:0] {
		OP_INIT  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_BAD   = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// Controller to datapath
	typedef struct packed {
		logic    capture;
		logic    init_start;
		logic    init_size;
		logic    init_clamp;
		logic    push_fill;
		logic    push_free;
		logic    pop;
		logic    load_res;
		logic    res_addr;
		status_t res_st;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic depth_zero;
		logic full;
		logic free_bad;
		logic fill_done;
		logic init_full;
		logic slot_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/ppfl_intf.sv =====
// Handshake interfaces for the request, response and configuration channels.
`timescale 1ns / 1ps
`default_nettype none

interface ppfl_req_if import ppfl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        operation;
	logic [ADDR_W-1:0] page_address;

	modport source (output valid, output operation, output page_address, input ready);
	modport sink   (input valid, input operation, input page_address, output ready);
endinterface

interface ppfl_rsp_if import ppfl_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [ADDR_W-1:0]      alloc_address;
	logic [1:0]             status;
	logic [COUNT_OUT_W-1:0] free_count;

	modport source (output valid, output alloc_address, output status, output free_count,
		input ready);
	modport sink   (input valid, input alloc_address, input status, input free_count,
		output ready);
endinterface

interface ppfl_cfg_if import ppfl_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [ADDR_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ppfl_dp.sv =====
// Datapath: pool registers, free page stack, init sizing and response register.
`timescale 1ns / 1ps
`default_nettype none

module ppfl_dp import ppfl_pkg::*; #(
	parameter int PAGE_SIZE = DEF_PAGE_SIZE,
	parameter int MAX_PAGES = DEF_MAX_PAGES
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [ADDR_W-1:0] page_address,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	ppfl_cfg_if.sink               cfg,
	ppfl_rsp_if.source             rsp
);

	localparam int SHIFT = $clog2(PAGE_SIZE);
	localparam int ENT_W = ADDR_W - SHIFT;
	localparam int PG_W  = ADDR_W + 1 - SHIFT;
	localparam int CNT_W = $clog2(MAX_PAGES + 1);
	localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

	localparam logic [ADDR_W:0]  PG_MASK = (ADDR_W + 1)'(PAGE_SIZE - 1);
	localparam logic [PG_W-1:0]  MAX_PG  = PG_W'(MAX_PAGES);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAGES);

	logic [ADDR_W-1:0] base_q, limit_q;
	logic [ADDR_W-1:0] addr_q;
	logic              bad_q;
	logic [ADDR_W:0]   first_q;
	logic [PG_W-1:0]   pages_raw_q;
	logic [CNT_W-1:0]  pages_q;
	logic              init_full_q;
	logic [ENT_W-1:0]  np_q;
	logic [CNT_W-1:0]  depth_q, depth_d;
	logic [ENT_W-1:0]  rd_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	status_t           out_st_q;
	logic [COUNT_OUT_W-1:0] out_cnt_q;

	logic [ENT_W-1:0]  mem [MAX_PAGES];

	logic              bad_in;
	logic [ADDR_W:0]   first_d;
	logic [ADDR_W+1:0] diff;
	logic [CNT_W-1:0]  depth_m1;
	logic              mem_we;
	logic [ENT_W-1:0]  mem_wdata;

	assign cfg.ready = 1'b1;

	assign bad_in  = (|page_address[SHIFT-1:0]) || (page_address < base_q)
		|| (page_address >= limit_q);
	assign first_d = ({1'b0, base_q} + PG_MASK) & ~PG_MASK;
	assign diff    = {2'b00, limit_q} - {1'b0, first_q};
	assign depth_m1 = depth_q - CNT_W'(1);

	always_comb begin
		depth_d = depth_q;
		priority if (cmd.init_start) begin
			depth_d = '0;
		end else if (cmd.pop) begin
			depth_d = depth_m1;
		end else if (cmd.push_fill || cmd.push_free) begin
			depth_d = depth_q + CNT_W'(1);
		end else begin
			depth_d = depth_q;
		end
	end

	assign mem_we    = cmd.push_fill || cmd.push_free;
	assign mem_wdata = cmd.push_fill ? np_q : addr_q[ADDR_W-1:SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			limit_q     <= '0;
			depth_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_POOL_BASE:  base_q  <= cfg.data;
					REG_POOL_LIMIT: limit_q <= cfg.data;
				endcase
			end
			depth_q <= depth_d;
			if (cmd.load_res) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q <= page_address;
			bad_q  <= bad_in;
		end
		if (cmd.init_start) begin
			first_q <= first_d;
		end
		if (cmd.init_size) begin
			// negative difference means the pool is inverted: no pages
			pages_raw_q <= diff[ADDR_W+1] ? '0 : diff[ADDR_W:SHIFT];
			np_q        <= first_q[ADDR_W-1:SHIFT];
		end
		if (cmd.init_clamp) begin
			init_full_q <= pages_raw_q > MAX_PG;
			pages_q     <= (pages_raw_q > MAX_PG) ? MAX_CNT : pages_raw_q[CNT_W-1:0];
		end
		if (cmd.push_fill) begin
			np_q <= np_q + ENT_W'(1);
		end
		if (cmd.load_res) begin
			out_addr_q <= cmd.res_addr ? {rd_q, {SHIFT{1'b0}}} : '0;
			out_st_q   <= cmd.res_st;
			out_cnt_q  <= COUNT_OUT_W'(depth_d);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[depth_q[IDX_W-1:0]] <= mem_wdata;
		end
		if (cmd.pop) begin
			rd_q <= mem[depth_m1[IDX_W-1:0]];
		end
	end

	assign sts.depth_zero = (depth_q == '0);
	assign sts.full       = (depth_q == MAX_CNT);
	assign sts.free_bad   = bad_q;
	assign sts.fill_done  = (depth_q == pages_q);
	assign sts.init_full  = init_full_q;
	assign sts.slot_free  = !out_valid_q || rsp.ready;

	assign rsp.valid         = out_valid_q;
	assign rsp.alloc_address = out_addr_q;
	assign rsp.status        = out_st_q;
	assign rsp.free_count    = out_cnt_q;

endmodule

`default_nettype wire

// ===== rtl/ppfl_ctl.sv =====
// Controller: sequences init, alloc and free requests over the datapath.
`timescale 1ns / 1ps
`default_nettype none

module ppfl_ctl import ppfl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	ppfl_req_if.sink  req,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RESULT,
		S_FREE,
		S_INIT_SIZE,
		S_INIT_CLAMP,
		S_INIT_FILL
	} state_t;

	state_t  state_q;
	status_t res_st_q;
	logic    res_addr_q;
	logic    acc;
	op_t     op;

	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign op        = op_t'(req.operation);

	always_comb begin
		cmd          = '0;
		cmd.res_st   = res_st_q;
		cmd.res_addr = res_addr_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					cmd.capture = 1'b1;
					unique case (op)
						OP_INIT:  cmd.init_start = 1'b1;
						OP_ALLOC: cmd.pop = !sts.depth_zero;
						OP_FREE:  ;
						OP_NONE:  ;
					endcase
				end
			end
			S_RESULT: cmd.load_res = sts.slot_free;
			S_FREE: begin
				cmd.res_addr = 1'b0;
				priority if (sts.free_bad) begin
					cmd.res_st = ST_BAD;
				end else if (sts.full) begin
					cmd.res_st = ST_FULL;
				end else begin
					cmd.res_st = ST_OK;
				end
				// push and report in the same edge
				if (sts.slot_free) begin
					cmd.load_res  = 1'b1;
					cmd.push_free = !sts.free_bad && !sts.full;
				end
			end
			S_INIT_SIZE:  cmd.init_size  = 1'b1;
			S_INIT_CLAMP: cmd.init_clamp = 1'b1;
			S_INIT_FILL:  cmd.push_fill  = !sts.fill_done;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			res_st_q   <= ST_OK;
			res_addr_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						unique case (op)
							OP_INIT:  state_q <= S_INIT_SIZE;
							OP_ALLOC: begin
								res_st_q   <= sts.depth_zero ? ST_EMPTY : ST_OK;
								res_addr_q <= !sts.depth_zero;
								state_q    <= S_RESULT;
							end
							OP_FREE:  state_q <= S_FREE;
							OP_NONE: begin
								res_st_q   <= ST_OK;
								res_addr_q <= 1'b0;
								state_q    <= S_RESULT;
							end
						endcase
					end
				end
				S_RESULT: begin
					if (sts.slot_free) begin
						state_q <= S_IDLE;
					end
				end
				S_FREE: begin
					if (sts.slot_free) begin
						state_q <= S_IDLE;
					end
				end
				S_INIT_SIZE:  state_q <= S_INIT_CLAMP;
				S_INIT_CLAMP: state_q <= S_INIT_FILL;
				S_INIT_FILL: begin
					if (sts.fill_done) begin
						res_st_q   <= sts.init_full ? ST_FULL : ST_OK;
						res_addr_q <= 1'b0;
						state_q    <= S_RESULT;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/physical_page_free_list_allocator.sv =====
// Top level of the physical page free list allocator.
`timescale 1ns / 1ps
`default_nettype none

// Page frame allocator holding free page numbers on a LIFO stack in a memory of
// MAX_PAGES entries. Alloc pops the stack, if it is not empty, when the request is
// taken, then loads the response register; free checks the address, then pushes it
// and loads the response register together; the unused operation code only loads it.
// Init fills the stack with the whole pages between the rounded-up pool base and the
// pool limit, capped at MAX_PAGES, one page per cycle through the write port. Stack
// contents need no clearing after reset, since only entries below the current depth
// are ever read. Write pool_base and pool_limit only while no request is in flight.
module physical_page_free_list_allocator import ppfl_pkg::*; #(
	parameter int PAGE_SIZE = DEF_PAGE_SIZE,
	parameter int MAX_PAGES = DEF_MAX_PAGES
) (
	input wire logic   clk,
	input wire logic   arst_n,
	ppfl_cfg_if.sink   cfg,
	ppfl_req_if.sink   req,
	ppfl_rsp_if.source rsp
);

	cmd_t cmd;
	sts_t sts;

	ppfl_ctl u_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.sts    (sts),
		.cmd    (cmd)
	);

	ppfl_dp #(
		.PAGE_SIZE (PAGE_SIZE),
		.MAX_PAGES (MAX_PAGES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.page_address (req.page_address),
		.cmd          (cmd),
		.sts          (sts),
		.cfg          (cfg),
		.rsp          (rsp)
	);

	// never overwrite a response that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_res |-> (!rsp.valid || rsp.ready))
		else $error("response register overwritten");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !sts.depth_zero)
		else $error("pop from empty stack");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_free || cmd.push_fill) |-> !sts.full)
		else $error("push onto full stack");

	a_init_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.operation == OP_INIT) |=> sts.depth_zero)
		else $error("init did not empty the stack");

endmodule

`default_nettype wire

// ===== tb/physical_page_free_list_allocator_test.sv =====
// Self-checking testbench for the page free list allocator: directed and random requests.
`timescale 1ns / 1ps

module physical_page_free_list_allocator_test;
	import ppfl_pkg::*;

	localparam longint unsigned PAGE_BYTES  = DEF_PAGE_SIZE;
	localparam int unsigned     STACK_SLOTS = DEF_MAX_PAGES;
	localparam int              CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [ADDR_W-1:0]      addr;
		status_t                st;
		logic [COUNT_OUT_W-1:0] count;
	} reply_t;

	// Tracks the free stack and pool registers, owes one reply per accepted request.
	class page_list_checker;
		logic [63:0]     pool_base;
		logic [63:0]     pool_limit;
		bit [27:0]       page_nums [STACK_SLOTS];
		int unsigned     depth;
		reply_t          owed_replies [$];
		logic [ADDR_W-1:0] lent_pages [$];
		int              errors;
		int              requests;
		int              replies;
		int              by_status [4];

		function new();
			pool_base  = '0;
			pool_limit = '0;
			depth      = 0;
			errors     = 0;
			requests   = 0;
			replies    = 0;
			foreach (by_status[i])
				by_status[i] = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
			if (idx == REG_POOL_BASE)
				pool_base = {24'd0, data};
			else if (idx == REG_POOL_LIMIT)
				pool_limit = {24'd0, data};
		endfunction

		function void apply_request(logic [1:0] op, logic [ADDR_W-1:0] addr);
			logic [63:0] first;
			logic [63:0] pages;
			logic [63:0] full_addr;
			reply_t      r;
			r.addr = '0;
			r.st   = ST_OK;
			requests++;
			case (op_t'(op))
				OP_INIT: begin
					first = (pool_base + PAGE_BYTES - 1) / PAGE_BYTES * PAGE_BYTES;
					pages = 0;
					depth = 0;
					lent_pages.delete();
					if (first + PAGE_BYTES <= pool_limit)
						pages = (pool_limit - first) / PAGE_BYTES;
					if (pages > STACK_SLOTS) begin
						pages = STACK_SLOTS;
						r.st  = ST_FULL;
					end
					for (longint unsigned i = 0; i < pages; i++) begin
						page_nums[depth] = 28'((first + i * PAGE_BYTES) / PAGE_BYTES);
						depth++;
					end
				end
				OP_ALLOC: begin
					if (depth == 0) begin
						r.st = ST_EMPTY;
					end else begin
						depth--;
						full_addr = 64'(page_nums[depth]) * PAGE_BYTES;
						r.addr = full_addr[ADDR_W-1:0];
						lent_pages.push_back(r.addr);
					end
				end
				OP_FREE: begin
					full_addr = {24'd0, addr};
					if (full_addr % PAGE_BYTES != 0 || full_addr < pool_base ||
						full_addr >= pool_limit) begin
						r.st = ST_BAD;
					end else if (depth >= STACK_SLOTS) begin
						r.st = ST_FULL;
					end else begin
						page_nums[depth] = 28'(full_addr / PAGE_BYTES);
						depth++;
					end
				end
				default: begin
				end
			endcase
			r.count = depth[COUNT_OUT_W-1:0];
			owed_replies.push_back(r);
		endfunction

		task flag(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_reply(logic [ADDR_W-1:0] a, logic [1:0] s, logic [COUNT_OUT_W-1:0] c);
			reply_t want;
			if (owed_replies.size() == 0) begin
				flag($sformatf("unexpected reply addr %h status %0d count %0d", a, s, c));
				return;
			end
			want = owed_replies.pop_front();
			replies++;
			by_status[int'(want.st)]++;
			if (a !== want.addr)
				flag($sformatf("reply %0d addr %h, want %h", replies, a, want.addr));
			if (s !== want.st)
				flag($sformatf("reply %0d status %0d, want %0d", replies, s, want.st));
			if (c !== want.count)
				flag($sformatf("reply %0d count %0d, want %0d", replies, c, want.count));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	ppfl_cfg_if cfg_ch ();
	ppfl_req_if req_ch ();
	ppfl_rsp_if rsp_ch ();

	physical_page_free_list_allocator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	page_list_checker sb;
	int               send_gap_pct;
	int               recv_stall_pct;
	int               cycle_count;
	logic [63:0]      pool_first;
	int               pool_pages;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
				sb.owed_replies.size());
			$display("physical_page_free_list_allocator_test: done, errors");
			$finish;
		end
	end

	// Check replies before noting new requests so a fresh expectation is never consumed early.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_reply(rsp_ch.alloc_address, rsp_ch.status, rsp_ch.free_count);
			if (req_ch.valid && req_ch.ready)
				sb.apply_request(req_ch.operation, req_ch.page_address);
			if (cfg_ch.valid && cfg_ch.ready)
				sb.write_reg(cfg_ch.index, cfg_ch.data);
		end
	end

	always @(negedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

	function automatic logic [ADDR_W-1:0] rand_addr();
		return {8'($urandom_range(255)), 32'($urandom())};
	endfunction

	function automatic logic [ADDR_W-1:0] pool_page(int k);
		logic [63:0] a;
		a = pool_first + PAGE_BYTES * k;
		return a[ADDR_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] bad_addr();
		logic [63:0] a;
		case ($urandom_range(3))
			0: a = pool_first + PAGE_BYTES * $urandom_range(pool_pages) + $urandom_range(1, 4095);
			1: a = pool_first - PAGE_BYTES * $urandom_range(1, 3);
			2: a = pool_first + PAGE_BYTES * (pool_pages + $urandom_range(2));
			default: a = {24'd0, rand_addr()};
		endcase
		return a[ADDR_W-1:0];
	endfunction

	// Call at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_request(op_t op, logic [ADDR_W-1:0] addr);
		while ($urandom_range(99) < send_gap_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid        = 1'b1;
		req_ch.operation    = op;
		req_ch.page_address = addr;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic settle();
		req_ch.valid = 1'b0;
		while (sb.owed_replies.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_pool(logic [ADDR_W-1:0] b, logic [ADDR_W-1:0] l);
		settle();
		write_reg(REG_POOL_BASE, b);
		write_reg(REG_POOL_LIMIT, l);
		pool_first = ({24'd0, b} + PAGE_BYTES - 1) / PAGE_BYTES * PAGE_BYTES;
		pool_pages = (pool_first + PAGE_BYTES <= {24'd0, l}) ?
			int'(({24'd0, l} - pool_first) / PAGE_BYTES) : 0;
	endtask

	// Random mix of allocs, frees of lent and pool pages, bad frees, inits and no-ops.
	task automatic run_mix(int n);
		int r;
		int k;
		logic [ADDR_W-1:0] a;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 4) begin
				send_request(OP_INIT, rand_addr());
			end else if (r < 44) begin
				send_request(OP_ALLOC, rand_addr());
			end else if (r < 78 && sb.lent_pages.size() != 0) begin
				k = $urandom_range(sb.lent_pages.size() - 1);
				a = sb.lent_pages[k];
				sb.lent_pages.delete(k);
				send_request(OP_FREE, a);
			end else if (r < 86 && pool_pages > 0) begin
				send_request(OP_FREE, pool_page($urandom_range(pool_pages - 1)));
			end else if (r < 95) begin
				send_request(OP_FREE, bad_addr());
			end else begin
				send_request(OP_NONE, rand_addr());
			end
		end
	endtask

	initial begin
		logic [63:0] b;
		logic [63:0] f;
		logic [63:0] l;
		sb                  = new();
		cycle_count         = 0;
		send_gap_pct        = 16;
		recv_stall_pct      = 73;
		pool_first          = '0;
		pool_pages          = 0;
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.operation    = OP_NONE;
		req_ch.page_address = '0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = REG_POOL_BASE;
		cfg_ch.data         = '0;
		rsp_ch.ready        = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset state: empty stack, zero pool
		send_request(OP_ALLOC, '0);
		send_request(OP_FREE, '0);
		send_request(OP_NONE, '1);
		send_request(OP_INIT, '0);

		// Unaligned base, five whole pages plus a partial one
		set_pool(40'h12_3456_7891, 40'(40'h12_3456_8000 + 5 * PAGE_BYTES + 40'h7FF));
		send_request(OP_INIT, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_FREE, pool_page(0) + 1);
		send_request(OP_FREE, pool_page(-1));
		send_request(OP_FREE, pool_page(6));
		send_request(OP_FREE, pool_page(3));
		repeat (5) send_request(OP_ALLOC, '0);

		// Inverted pool
		set_pool(40'h80_0000_0000, 40'h10_0000_0000);
		send_request(OP_INIT, '0);
		send_request(OP_FREE, 40'h80_0000_0000);

		// Top of the address space: rounding past the end, then the last pages
		set_pool('1, '1);
		send_request(OP_INIT, '0);
		set_pool(40'hFF_FFF0_0000, '1);
		send_request(OP_INIT, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_FREE, 40'hFF_FFFF_F000);

		// Exactly full stack, then one page too many
		set_pool('0, 40'h800_0000);
		send_request(OP_INIT, '0);
		send_request(OP_FREE, 40'h1000);
		send_request(OP_ALLOC, '0);
		set_pool('0, 40'h800_1FFF);
		send_request(OP_INIT, '0);

		for (int p = 0; p < 9; p++) begin
			case (p / 3)
				0: begin
					send_gap_pct   = 16;
					recv_stall_pct = 73;
				end
				1: begin
					send_gap_pct   = 73;
					recv_stall_pct = 16;
				end
				default: begin
					send_gap_pct   = 0;
					recv_stall_pct = 0;
				end
			endcase
			b = {24'd0, rand_addr()};
			f = (b + PAGE_BYTES - 1) / PAGE_BYTES * PAGE_BYTES;
			l = f + PAGE_BYTES * ((p == 4) ? $urandom_range(200, 600) : $urandom_range(1, 40))
				+ $urandom_range(4095);
			if (l > 64'hFF_FFFF_FFFF)
				l = 64'hFF_FFFF_FFFF;
			set_pool(b[ADDR_W-1:0], l[ADDR_W-1:0]);
			send_request(OP_INIT, rand_addr());
			run_mix(94);
		end

		settle();
		repeat (20) @(negedge clk);
		if (sb.owed_replies.size() != 0)
			sb.flag($sformatf("%0d replies never arrived", sb.owed_replies.size()));
		$display("covered %0d requests and %0d replies in %0d cycles", sb.requests, sb.replies,
			cycle_count);
		$display("reply status mix: ok %0d, empty %0d, bad address %0d, full %0d",
			sb.by_status[0], sb.by_status[1], sb.by_status[2], sb.by_status[3]);
		if (sb.errors == 0) begin
			$display("physical_page_free_list_allocator_test: done, clean");
		end else begin
			$display("physical_page_free_list_allocator_test: done, errors");
		end
		$finish;
	end

endmodule

// ===== physical_page_free_list_allocator.f =====
rtl/ppfl_pkg.sv
rtl/ppfl_intf.sv
rtl/ppfl_dp.sv
rtl/ppfl_ctl.sv
rtl/physical_page_free_list_allocator.sv
tb/physical_page_free_list_allocator_test.sv
